>>> rtl/core/text_console_writer_core_assert.svh
// Assertion shorthands used by the console core RTL.
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("text console check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("text console check failed");

`endif

>>> rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int TAB_STOP    = 8;

  localparam logic [7:0] ATTR_RESET = 8'h07;
  localparam logic [7:0] BLANK_CHAR = 8'h20;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [0:0] REG_TEXT_ATTR = 1'b0;

endpackage

>>> rtl/core/text_console_writer_core.sv
`timescale 1ns / 1ps
// Text console engine: a ROWS x COLUMNS screen of 16-bit cells (attribute in the
// high byte, character in the low byte) with a cursor. A request is taken when
// start is high and busy is low, and its single result appears on the out_ ports
// for exactly one cycle with out_valid; the receiver cannot stall it, so it must
// take every strobe. Putting a character that does not scroll and reading a cell
// each pass through the ST_REPORT state and then the out_valid register from
// acceptance to the strobe, and a new request can be accepted in the strobe
// cycle. The cell memory has one write port, so every bulk operation (the copy
// and fill of a scroll, a clear screen) runs one cell per cycle. After reset
// the block clears the screen with busy high; register writes are taken at any
// time.

`include "text_console_writer_core_assert.svh"

module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  output logic [10:0] out_cursor_position,
  output logic [4:0]  out_cursor_row_out,
  output logic [6:0]  out_cursor_col_out,
  output logic        out_scrolled,
  output logic [15:0] out_cell_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_LAST  = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] FILL_FIRST = AW'(CELLS - COLUMNS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_COPY   = 3'd2;
  localparam logic [2:0] ST_FILL   = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;

  logic [2:0]    state_r;
  logic [AW-1:0] cnt_r;
  logic [AW-1:0] wr_addr_r;
  logic          pend_r;
  logic          clr_report_r;
  logic          scroll_flag_r;
  logic          word_sel_r;
  logic [7:0]    attr_r;

  logic          out_valid_r;
  logic [10:0]   out_pos_r;
  logic [4:0]    out_row_r;
  logic [6:0]    out_col_r;
  logic          out_scrolled_r;
  logic [15:0]   out_word_r;

  logic          accept;
  logic          put;
  logic          home;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [AW-1:0] cur_pos;
  logic          put_char;
  logic          need_scroll;

  logic [31:0]   idx_ext;
  logic          cell_ok;
  logic [31:0]   pos_ext;
  logic [31:0]   row_ext;
  logic [31:0]   col_ext;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  logic          cfg_wr;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign put    = accept && (in_mode == MODE_PUT);
  assign home   = accept && (in_mode == MODE_CLEAR);

  assign idx_ext = 32'(in_cell_index);
  assign cell_ok = (idx_ext < 32'(CELLS));

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (put),
    .home     (home),
    .ch       (in_char_code),
    .row      (cur_row),
    .col      (cur_col),
    .pos      (cur_pos),
    .put_char (put_char),
    .scroll   (need_scroll)
  );

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Memory port steering. During a scroll the read runs one row ahead of the
  // write, and each copied word is written in the cycle after it is read.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = {attr_r, BLANK_CHAR};
    ram_raddr = idx_ext[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (put && put_char) begin
          ram_we    = 1'b1;
          ram_waddr = cur_pos;
          ram_wdata = {attr_r, in_char_code};
        end
      end
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_COPY: begin
        ram_raddr = cnt_r + AW'(COLUMNS);
        ram_we    = pend_r;
        ram_waddr = wr_addr_r;
        ram_wdata = ram_rdata;
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (pend_r) begin
          ram_waddr = wr_addr_r;
          ram_wdata = ram_rdata;
        end
      end
      ST_REPORT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      cnt_r         <= '0;
      pend_r        <= 1'b0;
      clr_report_r  <= 1'b0;
      scroll_flag_r <= 1'b0;
      word_sel_r    <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cnt_r         <= '0;
            pend_r        <= 1'b0;
            scroll_flag_r <= 1'b0;
            word_sel_r    <= 1'b0;
            case (in_mode)
              MODE_PUT: begin
                scroll_flag_r <= need_scroll;
                state_r       <= need_scroll ? ST_COPY : ST_REPORT;
              end
              MODE_CLEAR: begin
                clr_report_r <= 1'b1;
                state_r      <= ST_CLEAR;
              end
              MODE_READ: begin
                word_sel_r <= cell_ok;
                state_r    <= ST_REPORT;
              end
              default: begin
                state_r <= ST_REPORT;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          if (cnt_r == LAST_CELL) begin
            clr_report_r <= 1'b0;
            state_r      <= clr_report_r ? ST_REPORT : ST_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_COPY: begin
          pend_r    <= 1'b1;
          wr_addr_r <= cnt_r;
          if (cnt_r == COPY_LAST) begin
            cnt_r   <= FILL_FIRST;
            state_r <= ST_FILL;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_FILL: begin
          if (pend_r) begin
            pend_r <= 1'b0;
          end else if (cnt_r == LAST_CELL) begin
            state_r <= ST_REPORT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_REPORT: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign pos_ext = 32'(cur_pos);
  assign row_ext = 32'(cur_row);
  assign col_ext = 32'(cur_col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_REPORT);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_REPORT) begin
      out_pos_r      <= pos_ext[10:0];
      out_row_r      <= row_ext[4:0];
      out_col_r      <= col_ext[6:0];
      out_scrolled_r <= scroll_flag_r;
      out_word_r     <= word_sel_r ? ram_rdata : 16'h0000;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_pos_r;
  assign out_cursor_row_out  = out_row_r;
  assign out_cursor_col_out  = out_col_r;
  assign out_scrolled        = out_scrolled_r;
  assign out_cell_word       = out_word_r;

  assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_TEXT_ATTR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_wr) begin
      attr_r <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2:2] == REG_TEXT_ATTR) ? {24'h000000, attr_r} : 32'h00000000;
  assign pready = 1'b1;

  `TCW_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_valid_r, state_r == ST_IDLE)
  `TCW_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_r != ST_IDLE)
  `TCW_ASSERT_NOW(a_cursor_range, clk, rst_n, 1'b1, (row_ext < 32'(ROWS)) && (col_ext < 32'(COLUMNS)))
  `TCW_ASSERT_NOW(a_scroll_bottom, clk, rst_n, (state_r == ST_REPORT) && scroll_flag_r, row_ext == 32'(ROWS - 1))

endmodule

>>> rtl/core/tcw_ram.sv
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/tcw_cursor.sv
`timescale 1ns / 1ps

module tcw_cursor
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic                             home,
  input  logic [7:0]                       ch,
  output logic [$clog2(ROWS)-1:0]          row,
  output logic [$clog2(COLUMNS)-1:0]       col,
  output logic [$clog2(ROWS*COLUMNS)-1:0]  pos,
  output logic                             put_char,
  output logic                             scroll
);

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int AW = $clog2(ROWS * COLUMNS);

  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic [CW:0]   col_x;
  logic [RW:0]   row_x;
  logic [31:0]   pos_full;

  always_comb begin
    col_x    = {1'b0, col_r};
    row_x    = {1'b0, row_r};
    put_char = 1'b0;
    case (ch)
      CH_LF: begin
        col_x = '0;
        row_x = row_x + 1'b1;
      end
      CH_CR: begin
        col_x = '0;
      end
      CH_TAB: begin
        col_x = ({1'b0, col_r} + (CW+1)'(TAB_STOP)) & ~((CW+1)'(TAB_STOP - 1));
      end
      CH_BS: begin
        if (col_r != '0) begin
          col_x = {1'b0, col_r} - 1'b1;
        end
      end
      default: begin
        put_char = 1'b1;
        col_x    = {1'b0, col_r} + 1'b1;
      end
    endcase
    if (col_x >= (CW+1)'(COLUMNS)) begin
      col_x = '0;
      row_x = row_x + 1'b1;
    end
    scroll = (row_x >= (RW+1)'(ROWS));
    // After a scroll the cursor sits on the bottom row.
    if (scroll) begin
      row_x = (RW+1)'(ROWS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (home) begin
      row_r <= '0;
      col_r <= '0;
    end else if (step) begin
      row_r <= row_x[RW-1:0];
      col_r <= col_x[CW-1:0];
    end
  end

  assign pos_full = 32'(row_r) * 32'(COLUMNS) + 32'(col_r);
  assign pos      = pos_full[AW-1:0];
  assign row      = row_r;
  assign col      = col_r;

endmodule
